@@ design/two_class_priority_queue_core_assert.svh @@
// Assertion macros for the checker file of the two-class priority queue.
`ifndef TWO_CLASS_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Checked property, muted while reset is high.
`define TPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also active during reset.
`define TPQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tpq_pkg.sv @@
// Shared constants, request codes and cell command type of the priority queue.
`default_nettype none
package tpq_pkg;

  localparam int TPQ_CAPACITY = 16;
  localparam int ID_W         = 15;
  localparam int CNT_OUT_W    = 5;

  // Request codes carried in the action field
  localparam logic [1:0] ACT_INSERT     = 2'd0;
  localparam logic [1:0] ACT_SERVE_PREF = 2'd1;
  localparam logic [1:0] ACT_SERVE_GEN  = 2'd2;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic            insert;     // write the request into the tail cell
    logic            shift;      // remove one entry, younger ones move forward
    logic            pref_mode;  // remove the oldest marked entry
    logic [ID_W-1:0] id;
    logic            mark;
  } tpq_cmd_t;

endpackage
`default_nettype wire

@@ design/tpq_cell.sv @@
// One queue slot: holds an id and its mark, compares, and shifts from its right neighbor.
`default_nettype none
module tpq_cell
  import tpq_pkg::*;
(
  input  wire logic            clk,
  input  wire tpq_cmd_t        cmd,
  input  wire logic            valid,       // slot is occupied
  input  wire logic            tail,        // first free slot
  input  wire logic            head,        // slot zero
  input  wire logic [ID_W-1:0] right_id,
  input  wire logic            right_mark,
  input  wire logic            pref_in,     // a marked entry sits further left
  input  wire logic            rm_in,       // removal point is further left
  input  wire logic [ID_W-1:0] srv_id_in,
  input  wire logic            srv_mark_in,
  output logic                 pref_out,
  output logic                 rm_out,
  output logic      [ID_W-1:0] srv_id_out,
  output logic                 srv_mark_out,
  output logic                 hit,
  output logic      [ID_W-1:0] id,
  output logic                 mark
);

  logic marked;
  logic rm_here;

  // Search chain: first marked entry or the head
  assign marked       = valid & mark;
  assign pref_out     = pref_in | marked;
  assign rm_here      = cmd.pref_mode ? (marked & ~pref_in) : head;
  assign rm_out       = rm_in | rm_here;
  assign srv_id_out   = srv_id_in | (rm_here ? id : '0);
  assign srv_mark_out = srv_mark_in | (rm_here & mark);

  // Duplicate compare
  assign hit = valid & (id == cmd.id);

  // Slot update: shift in from the right at and after the removal point, or take an insert
  always_ff @(posedge clk) begin
    if (cmd.shift && rm_out) begin
      id   <= right_id;
      mark <= right_mark;
    end else if (cmd.insert && tail) begin
      id   <= cmd.id;
      mark <= cmd.mark;
    end
  end

endmodule
`default_nettype wire

@@ design/two_class_priority_queue_core.sv @@
// The input transfer loads the request register; the cell row then runs on that request
// and loads the result register.
// A new request is taken only once the previous one has executed; execute waits while
// the output register holds an untaken result.
// Reset (rst, synchronous, high) empties the queue and drops any pending request/result.
// Slot contents are not cleared; only slots below the entry count are ever read.
`default_nettype none
module two_class_priority_queue_core
  import tpq_pkg::*;
#(
  parameter int CAPACITY = TPQ_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] entry_id, [16] is_preferential, zero pad
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [0] ok, [15:1] served_id, [20:16] total_count,
                                      // [25:21] preferential_count, zero pad
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Request and queue bookkeeping
  logic          busy;
  logic [1:0]    req_action;
  logic [15:0]   req_id;
  logic          req_mark;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pcount, pcount_next;

  // Result register
  logic                 out_valid;
  logic                 out_ok;
  logic [ID_W-1:0]      out_served;
  logic [CNT_OUT_W-1:0] out_total;
  logic [CNT_OUT_W-1:0] out_pref;

  // Cell row wiring
  tpq_cmd_t        cmd;
  logic            hit       [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  logic [ID_W-1:0] cell_id   [CAPACITY+1];
  logic            cell_mark [CAPACITY+1];
  logic            pref_c    [CAPACITY+1];
  logic            rm_c      [CAPACITY+1];
  logic [ID_W-1:0] srv_id_c  [CAPACITY+1];
  logic            srv_mark_c[CAPACITY+1];

  logic do_ins, do_srv, fire, dup, full;
  logic [31:0] tot32, pref32;

  assign pref_c[0]           = 1'b0;
  assign rm_c[0]             = 1'b0;
  assign srv_id_c[0]         = '0;
  assign srv_mark_c[0]       = 1'b0;
  assign cell_id[CAPACITY]   = '0;
  assign cell_mark[CAPACITY] = 1'b0;

  // Row of slots, oldest entry in cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tpq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .valid       (CW'(i) < count),
      .tail        (CW'(i) == count),
      .head        (i == 0),
      .right_id    (cell_id[i+1]),
      .right_mark  (cell_mark[i+1]),
      .pref_in     (pref_c[i]),
      .rm_in       (rm_c[i]),
      .srv_id_in   (srv_id_c[i]),
      .srv_mark_in (srv_mark_c[i]),
      .pref_out    (pref_c[i+1]),
      .rm_out      (rm_c[i+1]),
      .srv_id_out  (srv_id_c[i+1]),
      .srv_mark_out(srv_mark_c[i+1]),
      .hit         (hit[i]),
      .id          (cell_id[i]),
      .mark        (cell_mark[i])
    );
    assign hit_vec[i] = hit[i];
  end

  // Decide the request against the current queue
  always_comb begin
    dup    = |hit_vec;
    full   = (count == CW'(CAPACITY));
    do_ins = (req_action == ACT_INSERT) && !req_id[15] && !dup && !full;
    do_srv = ((req_action == ACT_SERVE_PREF) || (req_action == ACT_SERVE_GEN))
             && (count != '0);
    fire   = busy && (!out_valid || m_tready);

    cmd.insert    = fire && do_ins;
    cmd.shift     = fire && do_srv;
    cmd.pref_mode = (req_action == ACT_SERVE_PREF) && (pcount != '0);
    cmd.id        = req_id[ID_W-1:0];
    cmd.mark      = req_mark;

    count_next  = count;
    pcount_next = pcount;
    if (do_ins) begin
      count_next  = count + CW'(1);
      pcount_next = pcount + CW'(req_mark);
    end else if (do_srv) begin
      count_next  = count - CW'(1);
      pcount_next = pcount - CW'(srv_mark_c[CAPACITY]);
    end
    tot32  = 32'(count_next);
    pref32 = 32'(pcount_next);
  end

  // Request capture, queue counts and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      pcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && !busy) begin
        busy       <= 1'b1;
        req_action <= s_tuser;
        req_id     <= s_tdata[15:0];
        req_mark   <= s_tdata[16];
      end
      if (fire) begin
        busy       <= 1'b0;
        count      <= count_next;
        pcount     <= pcount_next;
        out_valid  <= 1'b1;
        out_ok     <= do_ins || do_srv;
        out_served <= do_srv ? srv_id_c[CAPACITY] : '0;
        out_total  <= tot32[CNT_OUT_W-1:0];
        out_pref   <= pref32[CNT_OUT_W-1:0];
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign s_tready = !busy;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_pref, out_total, out_served, out_ok};

endmodule
`default_nettype wire

@@ design/tpq_checker.sv @@
// Port-level checker for the two-class priority queue, bound to the top level.
`default_nettype none
`include "two_class_priority_queue_core_assert.svh"
module tpq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // A result waiting for the sink stays offered
  `TPQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  // No result right out of reset
  `TPQ_ASSERT_RST(a_rst_idle, rst |=> !m_tvalid, "result valid after reset")

  // Only one request in flight: intake closes after a transfer
  `TPQ_ASSERT(a_one_req, s_tvalid && s_tready |=> !s_tready, "second request taken early")

  // A rejected request reports no served id
  `TPQ_ASSERT(a_fail_id, m_tvalid && !m_tdata[0] |-> m_tdata[15:1] == 15'd0,
              "served id on failed request")

endmodule

bind two_class_priority_queue_core tpq_checker u_tpq_checker (.*);
`default_nettype wire

@@ tb/tb_two_class_priority_queue_core.sv @@
// Self-checking testbench for the two-class priority queue core.
module tb_two_class_priority_queue_core;
  import tpq_pkg::*;

  // Action code the block does not use; it must leave the queue untouched
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;   // cycles with no transfer before giving up
  localparam int LONG_HOLD   = 60;     // result side hold-off that backs up the input
  localparam int DRAIN_WAIT  = 8;      // cycles after the last result, well past latency

  // One result word as it appears on m_tdata, lowest field last
  typedef struct packed {
    logic [5:0]          pad;
    logic [4:0]          marked;
    logic [4:0]          total;
    logic [ID_W-1:0]     served;
    logic                ok;
  } queue_reply_t;

  // Mirror of the queue contents plus the list of replies still owed
  class queue_mirror;
    logic [ID_W-1:0] ids[TPQ_CAPACITY];
    logic            marks[TPQ_CAPACITY];
    int              fill;
    queue_reply_t    owed_replies[$];
    int              errors;
    int              requests;
    int              inserts_taken;
    int              inserts_refused;
    int              serves_done;
    int              serves_refused;
    int              peak_fill;

    function new();
      fill = 0;
      errors = 0;
      requests = 0;
      inserts_taken = 0;
      inserts_refused = 0;
      serves_done = 0;
      serves_refused = 0;
      peak_fill = 0;
    endfunction

    // Apply one accepted request and queue the reply it must produce
    function void predict_request(logic [1:0] act, logic [15:0] raw, logic mark);
      queue_reply_t reply;
      int           pos;
      bit           dup;
      bit           found;
      int           n_marked;
      reply = '0;
      requests++;
      case (act)
        ACT_INSERT: begin
          dup = 1'b0;
          for (int i = 0; i < fill; i++)
            if (ids[i] == raw[ID_W-1:0]) dup = 1'b1;
          if (!raw[15] && !dup && fill < TPQ_CAPACITY) begin
            ids[fill]   = raw[ID_W-1:0];
            marks[fill] = mark;
            fill++;
            reply.ok = 1'b1;
            inserts_taken++;
          end else begin
            inserts_refused++;
          end
        end
        ACT_SERVE_PREF, ACT_SERVE_GEN: begin
          if (fill > 0) begin
            pos = 0;
            found = 1'b0;
            // preferential serve takes the oldest marked entry, else the oldest
            if (act == ACT_SERVE_PREF) begin
              for (int i = 0; i < fill; i++)
                if (!found && marks[i]) begin
                  pos = i;
                  found = 1'b1;
                end
            end
            reply.served = ids[pos];
            for (int i = pos; i + 1 < fill; i++) begin
              ids[i]   = ids[i+1];
              marks[i] = marks[i+1];
            end
            fill--;
            reply.ok = 1'b1;
            serves_done++;
          end else begin
            serves_refused++;
          end
        end
        default: ;
      endcase
      n_marked = 0;
      for (int i = 0; i < fill; i++)
        n_marked += marks[i];
      reply.total  = fill[4:0];
      reply.marked = n_marked[4:0];
      if (fill > peak_fill) peak_fill = fill;
      owed_replies.push_back(reply);
    endfunction

    // Compare one result transfer against the oldest owed reply
    function void compare_result(logic [31:0] word);
      queue_reply_t got;
      queue_reply_t want;
      got = queue_reply_t'(word);
      if (owed_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: result 0x%08h with no request outstanding", $realtime, word);
        return;
      end
      want = owed_replies.pop_front();
      if (got.ok !== want.ok || got.served !== want.served || got.total !== want.total ||
          got.marked !== want.marked || got.pad !== want.pad) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR %0t: exp ok=%0d id=%0d total=%0d pref=%0d pad=%0h",
                    " | act ok=%0d id=%0d total=%0d pref=%0d pad=%0h"},
                   $realtime, want.ok, want.served, want.total, want.marked, want.pad,
                   got.ok, got.served, got.total, got.marked, got.pad);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [15:0] entry_id, [16] is_preferential, zero pad
  logic [1:0]  s_tuser = '0;    // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [0] ok, [15:1] served_id, [20:16] total_count,
                                // [25:21] preferential_count, zero pad

  bit          quiet_tail = 1'b0;
  bit          long_hold_req = 1'b0;
  queue_mirror book = new();

  two_class_priority_queue_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Offer one request and hold it until the transfer; valid stays high afterwards
  task automatic send_request(input logic [1:0] act, input logic [15:0] raw,
                              input logic mark);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'b0, mark, raw};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.predict_request(act, raw, mark);
  endtask

  // Random request; ids mostly from a small pool so duplicates are common
  task automatic send_random(input int insert_pct);
    int          roll;
    logic [1:0]  act;
    logic [15:0] raw;
    roll = $urandom_range(99);
    if (roll < 3) act = ACT_UNUSED;
    else if (roll < 3 + insert_pct) act = ACT_INSERT;
    else if ($urandom_range(1) == 1) act = ACT_SERVE_PREF;
    else act = ACT_SERVE_GEN;
    if ($urandom_range(9) == 0) raw = 16'($urandom);
    else raw = 16'($urandom_range(47));
    send_request(act, raw, 1'($urandom_range(1)));
  endtask

  // Occasional gap on the request side
  task automatic source_gap();
    if (!quiet_tail && $urandom_range(7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  // Result side: check every transfer, stall in bursts, one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) book.compare_result(m_tdata);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(5, 1) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, book.owed_replies.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, bad ids, duplicates, mark selection, full queue
    send_request(ACT_SERVE_PREF, 16'h0000, 1'b0);
    send_request(ACT_SERVE_GEN, 16'hFFFF, 1'b1);
    send_request(ACT_UNUSED, 16'h1234, 1'b1);
    send_request(ACT_INSERT, 16'h8000, 1'b1);
    send_request(ACT_INSERT, 16'hFFFF, 1'b0);
    send_request(ACT_INSERT, 16'h0000, 1'b0);
    send_request(ACT_INSERT, 16'h7FFF, 1'b1);
    send_request(ACT_INSERT, 16'h0000, 1'b1);
    send_request(ACT_SERVE_PREF, 16'h7FFF, 1'b1);
    // only an unmarked entry is left: preferential serve falls back to it
    send_request(ACT_SERVE_PREF, 16'h0000, 1'b0);
    for (int i = 1; i <= TPQ_CAPACITY; i++)
      send_request(ACT_INSERT, 16'(i * 1021), (i % 3) == 0);
    send_request(ACT_INSERT, 16'h2AAA, 1'b1);
    send_request(ACT_UNUSED, 16'h5555, 1'b0);

    // Random blocks, each with its own insert bias so the fill level wanders
    for (int blk = 0; blk < 24; blk++) begin
      pct = $urandom_range(90, 10);
      if (blk == 5) begin
        // result side stops for a while; keep offering so the input backs up
        long_hold_req = 1'b1;
        for (int k = 0; k < 24; k++) send_random(50);
      end
      for (int k = 0; k < 40; k++) begin
        send_random(pct);
        source_gap();
      end
    end

    // Closing stretch at full rate on both sides
    quiet_tail = 1'b1;
    for (int k = 0; k < 220; k++) send_random(k < 110 ? 70 : 30);
    s_tvalid <= 1'b0;

    while (book.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests: %0d inserts taken, %0d refused; %0d serves, %0d on empty.",
             book.requests, book.inserts_taken, book.inserts_refused,
             book.serves_done, book.serves_refused);
    $display("Queue reached %0d of %0d entries; %0d mismatches.",
             book.peak_fill, TPQ_CAPACITY, book.errors);
    if (book.errors == 0 && book.owed_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
